### hw/rtl/multi_waveform_sample_generator_top_assert.svh
// Assertion macros for the sample generator checker.
`ifndef MULTI_WAVEFORM_SAMPLE_GENERATOR_TOP_ASSERT_SVH
`define MULTI_WAVEFORM_SAMPLE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define MWSG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MWSG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mwsg_pkg.sv
`timescale 1ns / 1ps
package mwsg_pkg;

    localparam int MAX_PERIOD       = 1024;
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SAMPLE_FRAC_BITS = 14;

    localparam int WAVE_W   = 2;
    localparam int PLEN_W   = 11;
    localparam int IDX_W    = 10;
    localparam int SAMPLE_W = 16;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam int TAB_AW  = $clog2(SINE_TABLE_DEPTH);
    localparam int TAB_W   = SAMPLE_FRAC_BITS + 1;
    // phase = round(i * 8D / 2n); 8D is a power of two
    localparam int PHASE_W = TAB_AW + 3;

    // ramp magnitude multiplier m (up to n), divider operand widths
    localparam int MAG_W      = IDX_W + 3;
    localparam int QUOT_W     = 14;
    localparam int DIVS_W     = PLEN_W + 3;
    localparam int DIVD_W     = DIVS_W + QUOT_W;
    localparam int DIV_STEPS  = QUOT_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [SAMPLE_W-1:0] ONE_VAL      = SAMPLE_W'(1) << SAMPLE_FRAC_BITS;
    localparam logic [TAB_W-1:0]    TAB_ONE      = TAB_W'(1) << SAMPLE_FRAC_BITS;
    localparam logic [PLEN_W-1:0]   PERIOD_RESET = PLEN_W'(50);

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [WAVE_W-1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SQUARE   = 2'd1,
        WAVE_SAW      = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    typedef enum logic {
        REG_WAVEFORM = 1'b0,
        REG_PERIOD   = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_last;
    } dp_sts_t;

    typedef logic [TAB_W-1:0] sine_tab_t [SINE_TABLE_DEPTH];

    // sin(pi/2 * k/D) by a Q30 Taylor series, rounded to the sample fraction
    function automatic logic [TAB_W-1:0] sine_entry(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        longint          sum;
        int unsigned     shift;
        x     = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
        x2    = (x * x) >> 30;
        term  = x;
        sum   = longint'(x);
        shift = 30 - SAMPLE_FRAC_BITS;
        // odd terms up to x^17; term j divides by (2j)(2j+1)
        term  = ((term * x2) >> 30) / 64'd6;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 30) / 64'd20;
        sum   = sum + longint'(term);
        term  = ((term * x2) >> 30) / 64'd42;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 30) / 64'd72;
        sum   = sum + longint'(term);
        term  = ((term * x2) >> 30) / 64'd110;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 30) / 64'd156;
        sum   = sum + longint'(term);
        term  = ((term * x2) >> 30) / 64'd210;
        sum   = sum - longint'(term);
        term  = ((term * x2) >> 30) / 64'd272;
        sum   = sum + longint'(term);
        if (sum < 0)
            sum = 0;
        s = longint'(sum);
        if (shift > 0)
            s = (s + (64'd1 << (shift - 1))) >> shift;
        if (s > longint'(ONE_VAL))
            s = longint'(ONE_VAL);
        return TAB_W'(s);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            tab[k] = sine_entry(k);
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

### hw/rtl/mwsg_cfg.sv
`timescale 1ns / 1ps
module mwsg_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mwsg_pkg::PADDR_W-1:0]  paddr,
    input  logic [mwsg_pkg::PDATA_W-1:0]  pwdata,
    output logic [mwsg_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mwsg_pkg::wave_t               waveform,
    output logic [mwsg_pkg::PLEN_W-1:0]   period_len
);
    import mwsg_pkg::*;

    wave_t              waveform_reg, waveform_next;
    logic [PLEN_W-1:0]  period_reg, period_next;
    reg_idx_t           reg_idx;
    logic               wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);

    always_comb
    begin
        waveform_next = waveform_reg;
        period_next   = period_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_WAVEFORM: waveform_next = wave_t'(pwdata[WAVE_W-1:0]);
                REG_PERIOD:   period_next   = pwdata[PLEN_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_WAVEFORM: prdata = PDATA_W'(waveform_reg);
            REG_PERIOD:   prdata = PDATA_W'(period_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WAVE_SINE;
            period_reg   <= PERIOD_RESET;
        end
        else
        begin
            waveform_reg <= waveform_next;
            period_reg   <= period_next;
        end
    end

    assign waveform   = waveform_reg;
    assign period_len = period_reg;

endmodule

### hw/rtl/mwsg_ctrl.sv
`timescale 1ns / 1ps
module mwsg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tick_valid,
    input  logic              tick,
    output logic              tick_stall,
    output logic              sample_valid,
    input  logic              sample_stall,
    output mwsg_pkg::dp_cmd_t cmd,
    input  mwsg_pkg::dp_sts_t sts
);
    import mwsg_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !sample_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_valid && tick)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        tick_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                tick_stall = 1'b0;
                cmd.load   = tick_valid && tick;
            end
            ST_DIVIDE: cmd.step     = 1'b1;
            ST_FINISH: cmd.out_load = out_free;
            default:   cmd          = '0;
        endcase
    end

    // hold the word until taken, refill from the finish state
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (!sample_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign sample_valid = out_valid_reg;

endmodule

### hw/rtl/mwsg_dp.sv
`timescale 1ns / 1ps
module mwsg_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mwsg_pkg::dp_cmd_t                   cmd,
    output mwsg_pkg::dp_sts_t                   sts,
    input  mwsg_pkg::wave_t                     waveform,
    input  logic [mwsg_pkg::PLEN_W-1:0]         period_len,
    output logic signed [mwsg_pkg::SAMPLE_W-1:0] sample_value,
    output logic [mwsg_pkg::IDX_W-1:0]          sample_index,
    output logic                                period_end
);
    import mwsg_pkg::*;

    // sample index state
    logic [IDX_W-1:0]     position_reg, position_next;

    // operand setup
    logic [PLEN_W-1:0]    n_eff, n_minus1, idx_ext, rest, half_n, quarter_n, three_q_n;
    logic [PLEN_W:0]      three_n;
    logic [IDX_W-1:0]     idx;
    logic                 is_last;
    logic [MAG_W-1:0]     idx_x2, idx_x4, rest_x2, rest_x4, n_x2, mag;
    logic                 neg;
    logic [DIVS_W-1:0]    n_x5, divisor;
    logic [DIVD_W-1:0]    dividend;

    // item registers
    wave_t                wave_reg;
    logic                 neg_reg, sq_pos_reg, last_reg;
    logic [IDX_W-1:0]     idx_reg;

    // divider
    logic [DIVS_W-1:0]    divisor_reg, rem_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIVS_W:0]      rem_shift, rem_diff;
    logic                 rem_ge;

    // result
    logic [PHASE_W-1:0]   phase;
    logic                 wrap;
    logic [1:0]           quad;
    logic [TAB_AW-1:0]    k_off, tab_idx;
    logic [TAB_W-1:0]     tab_mag;
    logic [SAMPLE_W-1:0]  sine_mag, sine_val, ramp_mag, ramp_val, sample_next;
    logic [SAMPLE_W-1:0]  sample_value_reg;
    logic [IDX_W-1:0]     sample_index_reg;
    logic                 period_end_reg;

    always_comb
    begin
        if (period_len == '0)
            n_eff = PLEN_W'(1);
        else if (period_len > PLEN_W'(MAX_PERIOD))
            n_eff = PLEN_W'(MAX_PERIOD);
        else
            n_eff = period_len;
    end

    // a stale position past a shortened period restarts at zero
    assign idx       = ({1'b0, position_reg} < n_eff) ? position_reg : '0;
    assign idx_ext   = {1'b0, idx};
    assign n_minus1  = n_eff - PLEN_W'(1);
    assign is_last   = (idx_ext == n_minus1);
    assign rest      = n_eff - idx_ext;
    assign half_n    = n_eff >> 1;
    assign quarter_n = n_eff >> 2;
    assign three_n   = {n_eff, 1'b0} + {1'b0, n_eff};
    assign three_q_n = PLEN_W'(three_n >> 2);

    assign idx_x2  = MAG_W'(idx_ext) << 1;
    assign idx_x4  = MAG_W'(idx_ext) << 2;
    assign rest_x2 = MAG_W'(rest) << 1;
    assign rest_x4 = MAG_W'(rest) << 2;
    assign n_x2    = MAG_W'(n_eff) << 1;
    assign n_x5    = (DIVS_W'(n_eff) << 2) + DIVS_W'(n_eff);

    // ramp numerator is +/- m * ONE; quotient is round(m * ONE / 5n)
    always_comb
    begin
        mag = '0;
        neg = 1'b0;
        unique case (waveform)
            WAVE_SINE, WAVE_SQUARE:
            begin
                mag = '0;
                neg = 1'b0;
            end
            WAVE_SAW:
            begin
                if (idx_ext <= half_n)
                    mag = idx_x2;
                else
                begin
                    mag = rest_x2;
                    neg = 1'b1;
                end
            end
            WAVE_TRIANGLE:
            begin
                if (idx_ext <= quarter_n)
                    mag = idx_x4;
                else if (idx_ext <= three_q_n)
                begin
                    if (idx_x4 > n_x2)
                    begin
                        mag = idx_x4 - n_x2;
                        neg = 1'b1;
                    end
                    else
                        mag = n_x2 - idx_x4;
                end
                else
                begin
                    mag = rest_x4;
                    neg = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        if (waveform == WAVE_SINE)
        begin
            dividend = (DIVD_W'(idx) << PHASE_W) + DIVD_W'(n_eff);
            divisor  = DIVS_W'(n_eff) << 1;
        end
        else
        begin
            dividend = (DIVD_W'(mag) << (SAMPLE_FRAC_BITS + 1)) + DIVD_W'(n_x5);
            divisor  = n_x5 << 1;
        end
    end

    assign position_next = is_last ? '0 : IDX_W'(idx_ext + PLEN_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            position_reg <= '0;
        else if (cmd.load)
            position_reg <= position_next;
    end

    // restoring divider, one quotient bit per step
    assign rem_shift = {rem_reg, quot_reg[QUOT_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};
    assign rem_ge    = (rem_shift >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            wave_reg    <= waveform;
            neg_reg     <= neg;
            sq_pos_reg  <= (idx_ext < half_n);
            last_reg    <= is_last;
            idx_reg     <= idx;
            divisor_reg <= divisor;
            rem_reg     <= dividend[DIVD_W-1:QUOT_W];
            quot_reg    <= dividend[QUOT_W-1:0];
            cnt_reg     <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg  <= rem_ge ? rem_diff[DIVS_W-1:0] : rem_shift[DIVS_W-1:0];
            quot_reg <= {quot_reg[QUOT_W-2:0], rem_ge};
            cnt_reg  <= cnt_reg + DIV_CNT_W'(1);
        end
    end

    assign sts.div_last = (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));

    // sine: fold the phase into a quadrant and a quarter-table offset
    assign phase    = quot_reg[PHASE_W-1:0];
    assign wrap     = phase[PHASE_W-1];
    assign quad     = wrap ? 2'b00 : phase[TAB_AW+1:TAB_AW];
    assign k_off    = wrap ? '0 : phase[TAB_AW-1:0];
    assign tab_idx  = quad[0] ? ('0 - k_off) : k_off;
    assign tab_mag  = (quad[0] && (k_off == '0)) ? TAB_ONE : SINE_TAB[tab_idx];
    assign sine_mag = SAMPLE_W'(tab_mag);
    assign sine_val = quad[1] ? ('0 - sine_mag) : sine_mag;

    assign ramp_mag = SAMPLE_W'(quot_reg);
    assign ramp_val = neg_reg ? ('0 - ramp_mag) : ramp_mag;

    always_comb
    begin
        unique case (wave_reg)
            WAVE_SINE:               sample_next = sine_val;
            WAVE_SQUARE:             sample_next = sq_pos_reg ? ONE_VAL : ('0 - ONE_VAL);
            WAVE_SAW, WAVE_TRIANGLE: sample_next = ramp_val;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            sample_value_reg <= sample_next;
            sample_index_reg <= idx_reg;
            period_end_reg   <= last_reg;
        end
    end

    assign sample_value = sample_value_reg;
    assign sample_index = sample_index_reg;
    assign period_end   = period_end_reg;

endmodule

### hw/rtl/multi_waveform_sample_generator_top.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Word
// -------   ---------  -------------------  -----------------------------------------
// tick      in         tick_valid/stall     tick
// sample    out        sample_valid/stall   sample_value, sample_index, period_end
// config    in         APB (psel/penable)   waveform @0x0, period_len @0x4
//
// One word in flight: accept, step the restoring divider, then form the sample
// in the finish state once the output register is free; the next tick word is
// taken back in idle. A tick word with tick low is absorbed in the idle state.
// Reset (rst_n low, asynchronous) clears the sample index and sets the
// registers to sine and a period of 50. A stalled sample holds the output
// register; the next tick is still taken and waits finished in the datapath.
module multi_waveform_sample_generator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mwsg_pkg::PADDR_W-1:0]        paddr,
    input  logic [mwsg_pkg::PDATA_W-1:0]        pwdata,
    output logic [mwsg_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready,
    input  logic                                tick_valid,
    output logic                                tick_stall,
    input  logic                                tick,
    output logic                                sample_valid,
    input  logic                                sample_stall,
    output logic signed [mwsg_pkg::SAMPLE_W-1:0] sample_value,
    output logic [mwsg_pkg::IDX_W-1:0]          sample_index,
    output logic                                period_end
);
    import mwsg_pkg::*;

    wave_t             waveform;
    logic [PLEN_W-1:0] period_len;
    dp_cmd_t           cmd;
    dp_sts_t           sts;

    mwsg_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .waveform   (waveform),
        .period_len (period_len)
    );

    mwsg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick_valid   (tick_valid),
        .tick         (tick),
        .tick_stall   (tick_stall),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .cmd          (cmd),
        .sts          (sts)
    );

    mwsg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .waveform     (waveform),
        .period_len   (period_len),
        .sample_value (sample_value),
        .sample_index (sample_index),
        .period_end   (period_end)
    );

endmodule

### hw/rtl/mwsg_checker.sv
`timescale 1ns / 1ps
`include "multi_waveform_sample_generator_top_assert.svh"
module mwsg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        tick_valid,
    input logic        tick_stall,
    input logic        tick,
    input logic        sample_valid,
    input logic        sample_stall,
    input logic signed [15:0] sample_value,
    input logic [9:0]  sample_index,
    input logic        period_end
);

    logic [26:0] out_word;
    logic        out_held;
    logic        in_range;
    logic        tick_taken;

    assign out_word   = {sample_value, sample_index, period_end};
    assign out_held   = sample_valid && sample_stall;
    assign in_range   = (sample_value >= -16'sd16384) && (sample_value <= 16'sd16384);
    assign tick_taken = tick_valid && !tick_stall;

    `MWSG_ASSERT_NXT(a_hold, out_held, sample_valid && $stable(out_word), "stalled word changed")

    `MWSG_ASSERT_NOW(a_sample_range, sample_valid, in_range, "sample outside +/-1.0")

    `MWSG_ASSERT_NXT(a_busy_after_tick, tick_taken && tick, tick_stall, "tick taken while busy")

    `MWSG_ASSERT_NXT(a_no_instant_sample, tick_taken, !$rose(sample_valid), "sample too early")

endmodule

bind multi_waveform_sample_generator_top mwsg_checker u_mwsg_checker (.*);

### tb/sv/multi_waveform_sample_generator_top_test.sv
`timescale 1ns / 1ps
module multi_waveform_sample_generator_top_test;
    import mwsg_pkg::*;

    localparam int              UNIT          = 1 << SAMPLE_FRAC_BITS;
    localparam longint unsigned HALF_PI_FX    = 64'd1686629713;
    localparam int              SETTLE_CYCLES = 40;
    localparam int              HOLD_CYCLES   = 400;
    localparam int              RANDOM_TICKS  = 1750;

    typedef struct {
        logic signed [SAMPLE_W-1:0] value;
        logic [IDX_W-1:0]           index;
        logic                       last;
    } sample_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                   psel    = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite  = 1'b0;
    logic [PADDR_W-1:0]     paddr   = '0;
    logic [PDATA_W-1:0]     pwdata  = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    logic                   tick_valid   = 1'b0;
    logic                   tick_stall;
    logic                   tick         = 1'b0;
    logic                   sample_valid;
    logic                   sample_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [IDX_W-1:0]       sample_index;
    logic                   period_end;

    // generator copy: registers, sample position, quarter-wave table
    wave_t                  cur_wave   = WAVE_SINE;
    logic [PLEN_W-1:0]      cur_period = PERIOD_RESET;
    int unsigned            next_pos   = 0;
    int                     quarter_sin [SINE_TABLE_DEPTH + 1];

    bit                     tick_queue [$];
    sample_t                samples_due [$];
    int                     errors     = 0;
    bit                     idle_on    = 1'b0;
    int                     gap_left   = 0;
    int                     stall_left = 0;
    int                     wait_now;
    logic                   offering;
    int                     hold_asks  = 0;
    int                     hold_seen  = 0;
    int                     hold_left  = 0;

    multi_waveform_sample_generator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .tick_valid   (tick_valid),
        .tick_stall   (tick_stall),
        .tick         (tick),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample_value (sample_value),
        .sample_index (sample_index),
        .period_end   (period_end)
    );

    always #10 clk = ~clk;

    function automatic void report_error(input string msg);
        errors++;
        if (errors <= 10)
            $display("%s", msg);
    endfunction

    // sin(pi/2 * k/D) as a Q30 Taylor series up to x^17, rounded to Q1.14
    function automatic int quarter_sine_entry(input int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned rnd;
        longint          acc;
        int unsigned     shift;
        ang    = 64'(k) * HALF_PI_FX / 64'(SINE_TABLE_DEPTH);
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        acc    = longint'(ang);
        shift  = 30 - SAMPLE_FRAC_BITS;
        for (int j = 1; j <= 8; j++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * j) * (2 * j + 1));
            if (j % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        rnd = 64'(acc);
        if (shift > 0)
            rnd = (rnd + (64'd1 << (shift - 1))) >> shift;
        if (rnd > 64'(UNIT))
            rnd = 64'(UNIT);
        return int'(rnd);
    endfunction

    // round to nearest, ties away from zero
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q   = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic void predict_sample();
        int unsigned n;
        int unsigned i;
        int unsigned p;
        int unsigned quad;
        int unsigned k;
        longint      num_i;
        longint      num_n;
        longint      den;
        longint      v;
        sample_t     s;
        if (cur_period == '0)
            n = 1;
        else if (cur_period > PLEN_W'(MAX_PERIOD))
            n = MAX_PERIOD;
        else
            n = 32'(cur_period);
        // a position left over from a longer period restarts the period
        i     = (next_pos < n) ? next_pos : 0;
        num_i = longint'(i) * UNIT;
        num_n = longint'(n) * UNIT;
        den   = 5 * longint'(n);
        case (cur_wave)
            WAVE_SINE:
            begin
                p = (i * 8 * SINE_TABLE_DEPTH + n) / (2 * n);
                if (p >= 4 * SINE_TABLE_DEPTH)
                    p = 0;
                quad = p / SINE_TABLE_DEPTH;
                k    = p % SINE_TABLE_DEPTH;
                if (quad == 0 || quad == 2)
                    v = longint'(quarter_sin[k]);
                else
                    v = longint'(quarter_sin[SINE_TABLE_DEPTH - k]);
                if (quad >= 2)
                    v = -v;
            end
            WAVE_SQUARE:
                v = (i < n / 2) ? longint'(UNIT) : -longint'(UNIT);
            WAVE_SAW:
            begin
                if (i <= n / 2)
                    v = round_div(2 * num_i, den);
                else
                    v = round_div(2 * num_i - 2 * num_n, den);
            end
            default:
            begin
                if (i <= n / 4)
                    v = round_div(4 * num_i, den);
                else if (i <= (3 * n) / 4)
                    v = round_div(2 * num_n - 4 * num_i, den);
                else
                    v = round_div(4 * num_i - 4 * num_n, den);
            end
        endcase
        s.value = SAMPLE_W'(v);
        s.index = IDX_W'(i);
        s.last  = (i == n - 1);
        samples_due.push_back(s);
        next_pos = (i == n - 1) ? 0 : i + 1;
    endfunction

    // tick word driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid <= 1'b0;
            tick       <= 1'b0;
            gap_left   <= 0;
        end
        else
        begin
            offering = tick_valid;
            if (tick_valid && !tick_stall)
            begin
                if (tick)
                    predict_sample();
                offering = 1'b0;
            end
            if (!offering && tick_queue.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
                else
                begin
                    tick     <= tick_queue.pop_front();
                    offering = 1'b1;
                    gap_left <= idle_on ? $urandom_range(0, 19) : 0;
                end
            end
            tick_valid <= offering;
        end
    end

    // long receiver hold-off, started on request from the sequence
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_seen <= 0;
        end
        else if (hold_seen != hold_asks)
        begin
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_asks;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // sample word monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_stall <= 1'b0;
            stall_left   <= 0;
        end
        else
        begin
            wait_now = stall_left;
            if (sample_valid && !sample_stall)
            begin
                if (samples_due.size() == 0)
                    report_error($sformatf("unexpected sample: value %0d index %0d end %0b",
                                           sample_value, sample_index, period_end));
                else
                begin
                    sample_t want;
                    want = samples_due.pop_front();
                    if (sample_value !== want.value || sample_index !== want.index ||
                        period_end !== want.last)
                        report_error($sformatf(
                            "sample mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                            want.value, want.index, want.last,
                            sample_value, sample_index, period_end));
                end
                wait_now = idle_on ? $urandom_range(0, 19) : 0;
            end
            else if (wait_now != 0)
                wait_now = wait_now - 1;
            stall_left   <= wait_now;
            sample_stall <= (wait_now != 0) || (hold_left > 1);
        end
    end

    task automatic apb_xfer(input logic wr, input reg_idx_t idx, input logic [PDATA_W-1:0] wdata,
                            output logic [PDATA_W-1:0] rdata);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(idx) << 2;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_reg(input reg_idx_t idx);
        logic [PDATA_W-1:0] got;
        logic [PDATA_W-1:0] want;
        want = (idx == REG_WAVEFORM) ? PDATA_W'(cur_wave) : PDATA_W'(cur_period);
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want)
            report_error($sformatf("register %s read back %0h, expected %0h",
                                   idx.name(), got, want));
    endtask

    task automatic cfg_write(input reg_idx_t idx, input logic [PDATA_W-1:0] wdata);
        logic [PDATA_W-1:0] unused;
        apb_xfer(1'b1, idx, wdata, unused);
        if (idx == REG_WAVEFORM)
            cur_wave = wave_t'(wdata[WAVE_W-1:0]);
        else
            cur_period = wdata[PLEN_W-1:0];
        check_reg(idx);
    endtask

    // wait until every tick word is taken and every sample has come back
    task automatic drain();
        do
            @(negedge clk);
        while (tick_queue.size() != 0 || tick_valid || samples_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_ticks(input int count, input int zero_pct);
        for (int c = 0; c < count; c++)
        begin
            if ($urandom_range(0, 99) < zero_pct)
                tick_queue.push_back(1'b0);
            tick_queue.push_back(1'b1);
        end
        drain();
    endtask

    initial
    begin
        int                phase_no;
        int                random_done;
        int                count;
        logic [PLEN_W-1:0] plen;
        for (int k = 0; k < SINE_TABLE_DEPTH; k++)
            quarter_sin[k] = quarter_sine_entry(k);
        quarter_sin[SINE_TABLE_DEPTH] = UNIT;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, then a few ticks with an idle tick in between
        check_reg(REG_WAVEFORM);
        check_reg(REG_PERIOD);
        tick_queue = '{1'b1, 1'b0, 1'b1, 1'b1};
        drain();

        cfg_write(REG_WAVEFORM, PDATA_W'(WAVE_SQUARE));
        cfg_write(REG_PERIOD, 32'd4);
        run_ticks(5, 0);
        // zero period behaves as a period of one
        cfg_write(REG_WAVEFORM, PDATA_W'(WAVE_SAW));
        cfg_write(REG_PERIOD, 32'd0);
        run_ticks(2, 0);
        // over-long period clamps to the maximum
        cfg_write(REG_WAVEFORM, PDATA_W'(WAVE_TRIANGLE));
        cfg_write(REG_PERIOD, 32'd2047);
        run_ticks(3, 0);
        // shrink the period below the current position
        cfg_write(REG_PERIOD, 32'd2);
        run_ticks(2, 0);
        cfg_write(REG_WAVEFORM, PDATA_W'(WAVE_SINE));
        cfg_write(REG_PERIOD, 32'd1024);
        run_ticks(2, 0);

        phase_no    = 0;
        random_done = 0;
        while (random_done < RANDOM_TICKS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            if (phase_no == 2)
            begin
                // one full maximum-length sine period reaches every index
                cfg_write(REG_WAVEFORM, PDATA_W'(WAVE_SINE));
                cfg_write(REG_PERIOD, MAX_PERIOD);
                count = MAX_PERIOD + 6;
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    cfg_write(REG_WAVEFORM,
                              ($urandom() & 32'hFFFF_FFFC) | $urandom_range(0, 3));
                if ($urandom_range(0, 3) != 0)
                begin
                    case ($urandom_range(0, 9))
                        0:       plen = '0;
                        1:       plen = PLEN_W'(1);
                        2:       plen = PLEN_W'(MAX_PERIOD);
                        3:       plen = PLEN_W'($urandom_range(MAX_PERIOD + 1, 2047));
                        4:       plen = PLEN_W'(2047);
                        default: plen = PLEN_W'($urandom_range(2, 70));
                    endcase
                    cfg_write(REG_PERIOD, ($urandom() & 32'hFFFF_F800) | PDATA_W'(plen));
                end
                count = $urandom_range(10, 90);
            end
            if (phase_no == 1)
            begin
                // hold off the sample side while ticks keep coming
                idle_on = 1'b0;
                hold_asks++;
                count = 60;
            end
            run_ticks(count, 10);
            random_done += count;
            phase_no++;
        end

        if (samples_due.size() != 0)
            report_error($sformatf("%0d samples never arrived", samples_due.size()));
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/mwsg_pkg.sv
hw/rtl/mwsg_cfg.sv
hw/rtl/mwsg_ctrl.sv
hw/rtl/mwsg_dp.sv
hw/rtl/multi_waveform_sample_generator_top.sv
hw/rtl/mwsg_checker.sv
tb/sv/multi_waveform_sample_generator_top_test.sv
